/* src/sync_header_frame_router_unit_defines.svh */
// assertion helpers shared by the router modules
`ifndef SYNC_HEADER_FRAME_ROUTER_UNIT_DEFINES_SVH
`define SYNC_HEADER_FRAME_ROUTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sfr_pkg.sv */
package sfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam int PORT_COUNT   = 8;
  localparam int HEADER_BYTES = 5;

  // position of a word within the header burst
  localparam logic [2:0] HB_SYNC1 = 3'd0;
  localparam logic [2:0] HB_SYNC2 = 3'd1;
  localparam logic [2:0] HB_LEN   = 3'd2;
  localparam logic [2:0] HB_RSV   = 3'd3;
  localparam logic [2:0] HB_TYPE  = 3'(HEADER_BYTES - 1);

  // configuration register indexes
  localparam logic [1:0] CFG_FALLBACK_PORT   = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_ENABLED = 2'd1;
  localparam logic [1:0] CFG_PORT_OPEN_MASK  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_LEN,
    PH_RSV,
    PH_TYPE,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0] fallback_port;
    logic       default_enabled;
    logic [7:0] port_open_mask;
  } cfg_t;

  // one queued job for the back end: a header burst or one data word
  typedef struct packed {
    logic       is_hdr;
    logic [7:0] data;
    logic [2:0] port;
    logic [7:0] len;
    logic [7:0] rsv;
    logic       last;
  } cmd_t;

endpackage

/* src/sync_header_frame_router_unit.sv */
// path: a forwarded byte passes the front stage register, a queue slot and the output register
// throughput: one input word per cycle; one output word per cycle while dst_stall is low,
//   a header burst of five words comes from the type byte, held in a QUEUE_DEPTH job queue
// the input stalls only when the queue is full and the next job must be queued
// reset: synchronous, clears parser, route table mapped bits, config registers and queue
module sync_header_frame_router_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input words
  input  logic       src_valid,
  output logic       src_stall,
  input  logic       mode,
  input  logic [7:0] in_byte,
  input  logic [7:0] route_type,
  input  logic [2:0] route_port,
  input  logic       route_valid,
  // output words
  output logic       dst_valid,
  input  logic       dst_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_port,
  output logic       frame_end,
  output logic       run_end
);
  import sfr_pkg::*;

  cfg_t cfg;
  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  // config registers take a write on any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FALLBACK_PORT:   cfg.fallback_port   <= cfg_data[2:0];
        CFG_DEFAULT_ENABLED: cfg.default_enabled <= cfg_data[0];
        CFG_PORT_OPEN_MASK:  cfg.port_open_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: hunts for the sync pair, holds the header, looks up the route
  sfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .mode        (mode),
    .in_byte     (in_byte),
    .route_type  (route_type),
    .route_port  (route_port),
    .route_valid (route_valid),
    .push        (push),
    .push_cmd    (push_cmd),
    .full        (full)
  );

  // job queue decouples parsing from the header burst
  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // back: expands jobs into tagged output words
  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .out_byte  (out_byte),
    .out_port  (out_port),
    .frame_end (frame_end),
    .run_end   (run_end)
  );

endmodule

/* src/sfr_front.sv */
module sfr_front (
  input  logic            clk,
  input  logic            rst,
  input  sfr_pkg::cfg_t   cfg,
  input  logic            src_valid,
  output logic            src_stall,
  input  logic            mode,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      route_type,
  input  logic [2:0]      route_port,
  input  logic            route_valid,
  output logic            push,
  output sfr_pkg::cmd_t   push_cmd,
  input  logic            full
);
  import sfr_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  len, len_next;
  logic [7:0]  rsv, rsv_next;
  logic [7:0]  left_dec;

  logic        accept, stream, route_wr;

  // route table: port in memory, mapped bit in flops
  logic [2:0]  route_mem [256];
  logic [255:0] mapped;
  logic [2:0]  rd_port;
  logic        rd_mapped;

  // stage between parser and queue
  logic        s1_valid;
  logic        s1_hdr, s1_last;
  logic [7:0]  s1_data, s1_len, s1_rsv;
  logic        take, take_hdr, take_last;

  logic        frame_fwd;
  logic [2:0]  frame_port;
  logic        have, open;
  logic [2:0]  sel_port;
  logic        s1_push, s1_advance;

  assign accept   = src_valid && !src_stall;
  assign stream   = accept && !mode;
  assign route_wr = accept && mode;
  assign left_dec = bytes_left - {7'd0, bytes_left != 8'd0};

  // next state of the parser
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    len_next        = len;
    rsv_next        = rsv;
    if (stream) begin
      unique case (phase)
        PH_HUNT: phase_next = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        PH_SYNC2: begin
          if (in_byte == SYNC_SECOND) begin
            phase_next = PH_LEN;
          end else if (in_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN: begin
          len_next   = in_byte;
          phase_next = PH_RSV;
        end
        PH_RSV: begin
          rsv_next   = in_byte;
          phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          bytes_left_next = len;
          phase_next      = (len == 8'd0) ? PH_HUNT : PH_DATA;
        end
        PH_DATA: begin
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            phase_next = PH_HUNT;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // parser outputs: which bytes become jobs
  always_comb begin
    take      = 1'b0;
    take_hdr  = 1'b0;
    take_last = 1'b0;
    unique case (phase)
      PH_TYPE: begin
        take      = stream;
        take_hdr  = 1'b1;
        take_last = (len == 8'd0);
      end
      PH_DATA: begin
        take      = stream;
        take_last = (left_dec == 8'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= 8'd0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    rsv <= rsv_next;
  end

  always_ff @(posedge clk) begin
    if (route_wr) begin
      route_mem[route_type] <= route_port;
    end
    if (stream) begin
      rd_port <= route_mem[in_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped <= '0;
    end else if (route_wr) begin
      mapped[route_type] <= route_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream) begin
      rd_mapped <= mapped[in_byte];
    end
  end

  // route decision on the type byte
  always_comb begin
    have     = rd_mapped || cfg.default_enabled;
    sel_port = rd_mapped ? rd_port : cfg.fallback_port;
    open     = have && (int'(sel_port) < PORT_COUNT) && cfg.port_open_mask[sel_port];
  end

  assign s1_push    = s1_valid && (s1_hdr ? open : frame_fwd);
  assign s1_advance = !s1_valid || !s1_push || !full;
  assign src_stall  = !s1_advance;
  assign push       = s1_push && s1_advance;

  always_comb begin
    push_cmd.is_hdr = s1_hdr;
    push_cmd.data   = s1_data;
    push_cmd.port   = s1_hdr ? sel_port : frame_port;
    push_cmd.len    = s1_len;
    push_cmd.rsv    = s1_rsv;
    push_cmd.last   = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      frame_fwd <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= take;
      if (s1_valid && s1_hdr) begin
        frame_fwd <= open;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s1_hdr  <= take_hdr;
      s1_last <= take_last;
      s1_data <= in_byte;
      s1_len  <= len;
      s1_rsv  <= rsv;
      if (s1_valid && s1_hdr) begin
        frame_port <= sel_port;
      end
    end
  end

endmodule

/* src/sfr_queue.sv */
module sfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::cmd_t head,
  output logic          empty
);
  import sfr_pkg::*;
  `include "sync_header_frame_router_unit_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFR_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `SFR_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty, "pop from empty queue")

endmodule

/* src/sfr_back.sv */
module sfr_back (
  input  logic          clk,
  input  logic          rst,
  input  sfr_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          dst_valid,
  input  logic          dst_stall,
  output logic [7:0]    out_byte,
  output logic [2:0]    out_port,
  output logic          frame_end,
  output logic          run_end
);
  import sfr_pkg::*;
  `include "sync_header_frame_router_unit_defines.svh"

  logic [2:0] beat;
  logic       load, emit, last_beat;
  logic [7:0] word;

  assign load      = !dst_valid || !dst_stall;
  assign emit      = load && !empty;
  assign last_beat = !head.is_hdr || (beat == HB_TYPE);
  assign pop       = emit && last_beat;

  always_comb begin
    if (head.is_hdr) begin
      unique case (beat)
        HB_SYNC1: word = SYNC_FIRST;
        HB_SYNC2: word = SYNC_SECOND;
        HB_LEN:   word = head.len;
        HB_RSV:   word = head.rsv;
        default:  word = head.data;
      endcase
    end else begin
      word = head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= HB_SYNC1;
      dst_valid <= 1'b0;
    end else begin
      if (emit) begin
        beat <= last_beat ? HB_SYNC1 : beat + 3'd1;
      end
      if (load) begin
        dst_valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= word;
      out_port  <= head.port;
      frame_end <= last_beat && head.last;
      run_end   <= last_beat;
    end
  end

  `SFR_ASSERT_NOW(a_beat_in_hdr, clk, rst, beat != HB_SYNC1, !empty && head.is_hdr, "burst beat without header job")
  `SFR_ASSERT_NOW(a_fend_has_rend, clk, rst, dst_valid && frame_end, run_end, "frame end without run end")

endmodule
